@@ sv/dtl_pkg.sv @@
// Package for the DFA token lexer: token codes, keyword tables, result types.
// No dependencies; imported by every module of the lexer.
package dtl_pkg;

  // Sizing
  localparam int unsigned MAX_LENGTH    = 255;
  localparam int unsigned COUNTER_WIDTH = 16;
  localparam int unsigned LEN_W         = $clog2(MAX_LENGTH + 1);
  localparam int unsigned NKW           = 9;
  localparam int unsigned KW_MAXLEN     = 10;
  localparam int unsigned NSYM          = 9;

  // Result queue sizing
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Token codes
  localparam logic [4:0] CODE_ERR     = 5'd0;
  localparam logic [4:0] CODE_LPAREN  = 5'd1;
  localparam logic [4:0] CODE_RPAREN  = 5'd2;
  localparam logic [4:0] CODE_LBRACE  = 5'd3;
  localparam logic [4:0] CODE_RBRACE  = 5'd4;
  localparam logic [4:0] CODE_KW_BASE = 5'd5;
  localparam logic [4:0] CODE_SYM_BASE = 5'd14;
  localparam logic [4:0] CODE_IDENT   = 5'd23;
  localparam logic [4:0] CODE_STRING  = 5'd24;

  // Characters with a role of their own
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Keywords, right-justified: first character sits in the highest used byte
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [NKW] = '{
    "class", "struct", "public", "private", "protected",
    "extends", "implements", "override", "virtual"
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd5, 4'd6, 4'd6, 4'd7, 4'd9, 4'd7, 4'd10, 4'd8, 4'd7
  };

  // Single-character symbols, in code order
  localparam logic [7:0] SYM_CHARS [NSYM] = '{
    ";", "*", ",", "&", "<", ">", ".", ":", "="
  };

  // One result transaction
  typedef struct packed {
    logic [4:0]  token_code;
    logic [15:0] token_ordinal;
    logic [7:0]  token_length;
    logic        is_error;
    logic        last_of_run;
  } dtl_res_t;

  // Results handed from the lexer core to the result queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    dtl_res_t   res0;
    dtl_res_t   res1;
  } dtl_push_t;

  // Character of keyword k at position pos; zero past the end of the keyword
  function automatic logic [7:0] kw_char(int k, logic [3:0] pos);
    int sh;
    sh = int'(KW_LEN[k]) - 1 - int'(pos);
    if (sh < 0) begin
      return 8'h00;
    end
    return KW_TEXT[k][8*sh +: 8];
  endfunction

  // Clip an open-token length to the 8-bit result field
  function automatic logic [7:0] len_out(logic [LEN_W-1:0] len);
    if (32'(len) > 32'd255) begin
      return 8'hFF;
    end
    return 8'(len);
  endfunction

endpackage

@@ sv/dtl_if.sv @@
// Channel interfaces of the DFA token lexer: source bytes in, tokens out.
// Depends on nothing but the built-in types.
interface dtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface dtl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_code;
  logic [15:0] token_ordinal;
  logic [7:0]  token_length;
  logic        is_error;
  logic        last_of_run;

  modport source (output valid, output token_code, output token_ordinal,
                  output token_length, output is_error, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_code, input token_ordinal,
                  input token_length, input is_error, input last_of_run,
                  output ready);
endinterface

@@ sv/dtl_rqueue.sv @@
// Result queue of the DFA token lexer: takes up to two results a cycle,
// delivers one per transaction. Depends on dtl_pkg and dtl_if.
module dtl_rqueue
  import dtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dtl_push_t push,
  output logic      room,
  dtl_out_if.source out_ch
);

  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] wr_ptr_p1;
  dtl_res_t           mem_r [Q_DEPTH];
  dtl_res_t           head;
  logic               pop;

  // Present the head entry
  assign head                 = mem_r[rd_ptr_r];
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.token_code    = head.token_code;
  assign out_ch.token_ordinal = head.token_ordinal;
  assign out_ch.token_length  = head.token_length;
  assign out_ch.is_error      = head.is_error;
  assign out_ch.last_of_run   = head.last_of_run;

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = (count_r <= Q_CNT_W'(Q_DEPTH - 2));

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_p1  = Q_PTR_W'(wr_ptr_r + 1'b1);
    wr_ptr_nxt = Q_PTR_W'(wr_ptr_r + push.cnt);
    rd_ptr_nxt = pop ? Q_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = Q_CNT_W'(count_r + push.cnt - Q_CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue over its depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("results pushed without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.cnt == 2'd0) |=> (count_r == Q_CNT_W'($past(count_r) - 1'b1)))
    else $error("pop did not drain the queue");
`endif

endmodule

@@ sv/dtl_core.sv @@
// Lexer core of the DFA token lexer: input byte register, lexer state and
// the per-byte step that yields up to two results. Depends on dtl_pkg, dtl_if.
module dtl_core
  import dtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dtl_in_if.sink    in_ch,
  input  logic      room,
  output dtl_push_t push
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;
  localparam logic [1:0] MODE_HALT   = 2'd3;

  logic [7:0]               byte_r;
  logic                     full_r, full_nxt;
  logic [1:0]               mode_r, mode_nxt;
  logic [NKW-1:0]           cand_r, cand_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [COUNTER_WIDTH-1:0] id_tot_r, id_tot_nxt;
  logic [COUNTER_WIDTH-1:0] str_tot_r, str_tot_nxt;

  logic                     advance, in_take;
  logic                     is_let, is_dig, is_spc, is_quote, is_word;
  logic                     sym_hit, sep_hit;
  logic [4:0]               sym_code, sep_code, single_code;
  logic [LEN_W-1:0]         len_inc, pos;
  logic [NKW-1:0]           keep, cand_base;
  logic                     kw_hit;
  logic [4:0]               kw_code;
  logic [COUNTER_WIDTH-1:0] id_inc, str_inc;
  logic [1:0]               n;
  logic                     err;
  dtl_res_t                 r0, r1;

  // Handshake: the byte register moves on when the queue has room for two
  assign advance     = full_r && room;
  assign in_ch.ready = !full_r || room;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign full_nxt    = in_take || (full_r && !advance);

  // Classify the byte
  always_comb begin
    is_let   = (byte_r >= "A" && byte_r <= "Z") || (byte_r >= "a" && byte_r <= "z");
    is_dig   = (byte_r >= "0" && byte_r <= "9");
    is_spc   = (byte_r == " ") || (byte_r == 8'h0A) || (byte_r == 8'h09) ||
               (byte_r == 8'h0D);
    is_quote = (byte_r == CH_QUOTE);
    is_word  = is_let || is_dig || (byte_r == CH_UNDER);
    sym_hit  = 1'b0;
    sym_code = CODE_ERR;
    for (int i = 0; i < NSYM; i++) begin
      if (byte_r == SYM_CHARS[i]) begin
        sym_hit  = 1'b1;
        sym_code = 5'(CODE_SYM_BASE + i);
      end
    end
    sep_hit = 1'b1;
    unique case (byte_r)
      "(":     sep_code = CODE_LPAREN;
      ")":     sep_code = CODE_RPAREN;
      "{":     sep_code = CODE_LBRACE;
      "}":     sep_code = CODE_RBRACE;
      default: begin
        sep_code = CODE_ERR;
        sep_hit  = 1'b0;
      end
    endcase
    single_code = sym_hit ? sym_code : sep_code;
  end

  // Keyword compare at the current position, and the match at identifier end
  always_comb begin
    pos       = (mode_r == MODE_IDLE) ? '0 : len_r;
    cand_base = (mode_r == MODE_IDLE) ? '1 : cand_r;
    kw_hit    = 1'b0;
    kw_code   = CODE_IDENT;
    for (int i = 0; i < NKW; i++) begin
      keep[i] = (32'(pos) < 32'(KW_LEN[i])) && (kw_char(i, pos[3:0]) == byte_r);
      if (cand_r[i] && (32'(len_r) == 32'(KW_LEN[i]))) begin
        kw_hit  = 1'b1;
        kw_code = 5'(CODE_KW_BASE + i);
      end
    end
  end

  assign len_inc = (32'(len_r) < MAX_LENGTH) ? LEN_W'(len_r + 1'b1) : len_r;
  assign id_inc  = COUNTER_WIDTH'(id_tot_r + 1'b1);
  assign str_inc = COUNTER_WIDTH'(str_tot_r + 1'b1);

  // One lexer step
  always_comb begin
    mode_nxt    = mode_r;
    cand_nxt    = cand_r;
    len_nxt     = len_r;
    id_tot_nxt  = id_tot_r;
    str_tot_nxt = str_tot_r;
    n           = 2'd0;
    err         = 1'b0;
    r0          = '0;
    r1          = '0;
    unique case (mode_r)
      MODE_IDLE: begin
        if (is_let || byte_r == CH_UNDER) begin
          mode_nxt = MODE_IDENT;
          cand_nxt = cand_base & keep;
          len_nxt  = LEN_W'(1);
        end else if (is_dig) begin
          id_tot_nxt       = id_inc;
          r0.token_code    = CODE_IDENT;
          r0.token_ordinal = 16'(id_inc);
          r0.token_length  = 8'd1;
          r0.last_of_run   = 1'b1;
          n                = 2'd1;
        end else if (is_spc) begin
          n = 2'd0;
        end else if (sym_hit || sep_hit) begin
          r0.token_code   = single_code;
          r0.token_length = 8'd1;
          r0.last_of_run  = 1'b1;
          n               = 2'd1;
        end else if (is_quote) begin
          mode_nxt = MODE_STRING;
          len_nxt  = LEN_W'(1);
        end else begin
          err = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_word) begin
          cand_nxt = cand_base & keep;
          len_nxt  = len_inc;
        end else if (!(is_spc || sym_hit || sep_hit || is_quote)) begin
          err = 1'b1;
        end else begin
          // Close the identifier, then handle the terminator as a fresh byte
          mode_nxt        = MODE_IDLE;
          r0.token_code   = kw_code;
          r0.token_length = len_out(len_r);
          if (!kw_hit) begin
            id_tot_nxt       = id_inc;
            r0.token_ordinal = 16'(id_inc);
          end
          if (sym_hit || sep_hit) begin
            r1.token_code   = single_code;
            r1.token_length = 8'd1;
            r1.last_of_run  = 1'b1;
            n               = 2'd2;
          end else begin
            r0.last_of_run = 1'b1;
            n              = 2'd1;
            if (is_quote) begin
              mode_nxt = MODE_STRING;
              len_nxt  = LEN_W'(1);
            end
          end
        end
      end
      MODE_STRING: begin
        len_nxt = len_inc;
        if (is_quote) begin
          mode_nxt         = MODE_IDLE;
          str_tot_nxt      = str_inc;
          r0.token_code    = CODE_STRING;
          r0.token_ordinal = 16'(str_inc);
          r0.token_length  = len_out(len_inc);
          r0.last_of_run   = 1'b1;
          n                = 2'd1;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
    // Unrecognized byte: drop any open identifier and halt
    if (err) begin
      mode_nxt       = MODE_HALT;
      r0             = '0;
      r0.token_code  = CODE_ERR;
      r0.is_error    = 1'b1;
      r0.last_of_run = 1'b1;
      n              = 2'd1;
    end
  end

  assign push.cnt  = advance ? n : 2'd0;
  assign push.res0 = r0;
  assign push.res1 = r1;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r    <= 1'b0;
      mode_r    <= MODE_IDLE;
      cand_r    <= '1;
      len_r     <= '0;
      id_tot_r  <= '0;
      str_tot_r <= '0;
    end else begin
      full_r <= full_nxt;
      if (advance) begin
        mode_r    <= mode_nxt;
        cand_r    <= cand_nxt;
        len_r     <= len_nxt;
        id_tot_r  <= id_tot_nxt;
        str_tot_r <= str_tot_nxt;
      end
    end
  end

  // Hold the input byte
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_ch.char_byte;
    end
  end

`ifndef SYNTHESIS
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HALT) |-> (push.cnt == 2'd0))
    else $error("results pushed while halted");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0 && push.res0.is_error) |=> (mode_r == MODE_HALT))
    else $error("error result without halt");

  a_two_only_ident: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (mode_r == MODE_IDENT && !push.res0.last_of_run &&
                            push.res1.last_of_run))
    else $error("two results outside an identifier close");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd3)
    else $error("bad push count");
`endif

endmodule

@@ sv/dfa_token_lexer.sv @@
// Top level of the DFA token lexer: byte channel in, token channel out.
// Depends on dtl_pkg, dtl_if, dtl_core and dtl_rqueue.
//
//   channel   dir  modport  payload
//   in_ch     in   sink     char_byte[7:0]
//   out_ch    out  source   token_code[4:0] token_ordinal[15:0] token_length[7:0]
//                           is_error last_of_run
//
// The byte register takes a byte at acceptance; the byte is stepped once the queue
// has room, and its results are written into the result queue before they leave.
// Throughput: one byte per cycle while the result queue has room for two;
// a byte that closes an identifier and is a symbol or bracket yields two results,
// and the single output port then sets the pace at one result per cycle.
// Reset (synchronous, rst_n low) returns the lexer to idle and empties the queue.
// A stall on out_ch fills the four-entry queue to three or four results; the
// byte register then holds its byte and in_ch.ready goes low.
module dfa_token_lexer
  import dtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dtl_in_if.sink    in_ch,
  dtl_out_if.source out_ch
);

  dtl_push_t push;
  logic      room;

  // Lexer step on each byte
  dtl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  // Queue results toward the output
  dtl_rqueue u_rqueue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

@@ sim/dtl_token_checker.sv @@
`timescale 1ns / 100ps
// Token checker for the DFA token lexer: tracks the lexer state per accepted byte,
// queues the predicted tokens and compares every token transaction leaving the block.
// Depends on dtl_pkg and the channel interfaces in dtl_if.
module dtl_token_checker
  import dtl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dtl_in_if    in_ch,
  dtl_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [1:0] {LX_IDLE, LX_IDENT, LX_STRING, LX_HALT} lex_mode_e;

  string kw_words [NKW] = '{"class", "struct", "public", "private", "protected",
                            "extends", "implements", "override", "virtual"};

  lex_mode_e        mode = LX_IDLE;
  logic [NKW-1:0]   kw_alive = '1;
  logic [7:0]       open_len = '0;
  logic [15:0]      ident_count = '0;
  logic [15:0]      quoted_count = '0;
  dtl_res_t         expected_tokens [$];
  int               errors = 0;

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic int symbol_slot(logic [7:0] b);
    for (int i = 0; i < NSYM; i++) begin
      if (SYM_CHARS[i] == b) return i;
    end
    return -1;
  endfunction

  function automatic logic [4:0] bracket_code(logic [7:0] b);
    case (b)
      "(": return CODE_LPAREN;
      ")": return CODE_RPAREN;
      "{": return CODE_LBRACE;
      "}": return CODE_RBRACE;
      default: return CODE_ERR;
    endcase
  endfunction

  function automatic void queue_token(logic [4:0] code, logic [15:0] ord, logic [7:0] len,
                                      logic err);
    dtl_res_t t;
    t.token_code    = code;
    t.token_ordinal = ord;
    t.token_length  = len;
    t.is_error      = err;
    t.last_of_run   = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void restart_lexer();
    mode         = LX_IDLE;
    kw_alive     = '1;
    open_len     = '0;
    ident_count  = '0;
    quoted_count = '0;
    expected_tokens.delete();
  endfunction

  // Drop every keyword whose character at the current position differs
  function automatic void narrow_keywords(logic [7:0] b);
    for (int i = 0; i < NKW; i++) begin
      if (!(int'(open_len) < kw_words[i].len() && kw_words[i][int'(open_len)] == b))
        kw_alive[i] = 1'b0;
    end
  endfunction

  function automatic void grow_length();
    if (open_len < MAX_LENGTH) open_len++;
  endfunction

  function automatic void flag_error();
    queue_token(CODE_ERR, 16'd0, 8'd0, 1'b1);
    mode = LX_HALT;
  endfunction

  // Handle one byte with no token open
  function automatic void lex_from_idle(logic [7:0] b);
    int sym;
    sym = symbol_slot(b);
    if (is_letter(b) || b == CH_UNDER) begin
      mode     = LX_IDENT;
      kw_alive = '1;
      open_len = '0;
      narrow_keywords(b);
      grow_length();
    end else if (is_digit(b)) begin
      ident_count++;
      queue_token(CODE_IDENT, ident_count, 8'd1, 1'b0);
    end else if (is_blank(b)) begin
      // whitespace gives nothing
    end else if (sym >= 0) begin
      queue_token(CODE_SYM_BASE + 5'(sym), 16'd0, 8'd1, 1'b0);
    end else if (bracket_code(b) != CODE_ERR) begin
      queue_token(bracket_code(b), 16'd0, 8'd1, 1'b0);
    end else if (b == CH_QUOTE) begin
      mode     = LX_STRING;
      open_len = 8'd1;
    end else begin
      flag_error();
    end
  endfunction

  // Extend the open identifier, close it and replay the byte from idle, or flag a bad byte
  function automatic void lex_in_ident(logic [7:0] b);
    logic [4:0]  code;
    logic [15:0] ord;
    if (is_letter(b) || b == CH_UNDER || is_digit(b)) begin
      narrow_keywords(b);
      grow_length();
    end else if (!is_blank(b) && symbol_slot(b) < 0 && bracket_code(b) == CODE_ERR &&
                 b != CH_QUOTE) begin
      flag_error();
    end else begin
      code = CODE_IDENT;
      ord  = 16'd0;
      for (int i = 0; i < NKW; i++) begin
        if (kw_alive[i] && int'(open_len) == kw_words[i].len()) code = CODE_KW_BASE + 5'(i);
      end
      if (code == CODE_IDENT) begin
        ident_count++;
        ord = ident_count;
      end
      queue_token(code, ord, open_len, 1'b0);
      mode = LX_IDLE;
      lex_from_idle(b);
    end
  endfunction

  function automatic void lex_in_string(logic [7:0] b);
    grow_length();
    if (b == CH_QUOTE) begin
      quoted_count++;
      queue_token(CODE_STRING, quoted_count, open_len, 1'b0);
      mode = LX_IDLE;
    end
  endfunction

  // Predict the tokens of one accepted byte; mark the last one of the run
  function automatic void lex_byte(logic [7:0] b);
    int prior_size;
    prior_size = expected_tokens.size();
    case (mode)
      LX_IDLE:   lex_from_idle(b);
      LX_IDENT:  lex_in_ident(b);
      LX_STRING: lex_in_string(b);
      default:   ;
    endcase
    if (expected_tokens.size() > prior_size)
      expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void match_token();
    dtl_res_t want;
    if (expected_tokens.size() == 0) begin
      $error("token_code: expected no token, got %0d", out_ch.token_code);
      errors++;
    end else begin
      want = expected_tokens.pop_front();
      check_field("token_code", want.token_code, out_ch.token_code);
      check_field("token_ordinal", want.token_ordinal, out_ch.token_ordinal);
      check_field("token_length", want.token_length, out_ch.token_length);
      check_field("is_error", want.is_error, out_ch.is_error);
      check_field("last_of_run", want.last_of_run, out_ch.last_of_run);
    end
  endfunction

  // Compare the outgoing transaction first, then predict from the incoming one
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_lexer();
    end else begin
      if (out_ch.valid && out_ch.ready) match_token();
      if (in_ch.valid && in_ch.ready) lex_byte(in_ch.char_byte);
    end
    pending    <= expected_tokens.size();
    fail_count <= errors;
  end

endmodule

@@ sim/dfa_token_lexer_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the DFA token lexer: drives source text, stalls the token side
// and reports the verdict. Depends on dtl_pkg, dtl_if, dfa_token_lexer, dtl_token_checker.
module dfa_token_lexer_tb;
  import dtl_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_LEN  = 1100;
  localparam int TAIL_LEN    = 160;

  logic clk;
  logic rst_n;

  dtl_in_if  in_ch ();
  dtl_out_if out_ch ();

  int fail_count;
  int pending;
  int feed_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int cycle_count = 0;

  logic [7:0] source_text [$];

  string kw_words [NKW] = '{"class", "struct", "public", "private", "protected",
                            "extends", "implements", "override", "virtual"};
  string blanks = " \t\n\r";
  string brackets = "(){}";
  string noise_chars = "aZq_5 \t\n;*,&<>.:=(){}";

  dfa_token_lexer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dtl_token_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the token side in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left   <= $urandom_range(0, 11);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_word_char(bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  // Quoted string whose body takes every byte value but the quote
  function automatic void add_string(int body_len);
    logic [7:0] b;
    source_text.push_back(CH_QUOTE);
    for (int i = 0; i < body_len; i++) begin
      b = 8'($urandom_range(0, 254));
      if (b >= CH_QUOTE) b++;
      source_text.push_back(b);
    end
    source_text.push_back(CH_QUOTE);
  endfunction

  function automatic void add_ident(int ident_len);
    source_text.push_back(pick_word_char(1'b1));
    for (int i = 1; i < ident_len; i++) source_text.push_back(pick_word_char(1'b0));
  endfunction

  // Byte that ends an identifier: blank, symbol, bracket or a whole string
  function automatic void add_closer();
    case ($urandom_range(0, 5))
      0: source_text.push_back(blanks[$urandom_range(0, 3)]);
      1: source_text.push_back(SYM_CHARS[$urandom_range(0, NSYM - 1)]);
      2: source_text.push_back(brackets[$urandom_range(0, 3)]);
      3: add_string($urandom_range(0, 6));
      default: source_text.push_back(8'h20);
    endcase
  endfunction

  function automatic void add_random_token();
    string w;
    int    pos;
    case ($urandom_range(0, 9))
      0, 1: begin
        add_text(kw_words[$urandom_range(0, NKW - 1)]);
        add_closer();
      end
      2: begin
        // near-miss keyword: cut short, left whole, capitalized or one letter off, sometimes extended
        w = kw_words[$urandom_range(0, NKW - 1)];
        case ($urandom_range(0, 3))
          0: w = w.substr(0, w.len() - 2);
          1: ;
          2: w.putc(0, w[0] - 8'd32);
          default: begin
            pos = $urandom_range(0, w.len() - 1);
            w.putc(pos, (w[pos] == "z") ? 8'("y") : w[pos] + 8'd1);
          end
        endcase
        add_text(w);
        if (w.len() > 0 && $urandom_range(0, 3) == 0) source_text.push_back(pick_word_char(0));
        add_closer();
      end
      3, 4: begin
        add_ident($urandom_range(1, 12));
        add_closer();
      end
      5: repeat ($urandom_range(1, 4)) source_text.push_back(8'("0" + $urandom_range(0, 9)));
      6: repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1) == 1) source_text.push_back(SYM_CHARS[$urandom_range(0, NSYM - 1)]);
        else source_text.push_back(brackets[$urandom_range(0, 3)]);
      end
      7: repeat ($urandom_range(1, 3)) source_text.push_back(blanks[$urandom_range(0, 3)]);
      8: add_string($urandom_range(0, 10));
      default: repeat ($urandom_range(1, 6))
        source_text.push_back(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 12;
    endcase
  endfunction

  // Present one byte and hold it until the transaction completes
  task automatic send_byte(logic [7:0] b);
    if (feed_odds != 0 && $urandom_range(1, feed_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Send the queued text, reshuffling the idle odds every 64 bytes when allowed
  task automatic send_text(bit idling);
    for (int i = 0; i < source_text.size(); i++) begin
      if (i % 64 == 0) begin
        feed_odds  = idling ? pick_odds() : 0;
        stall_odds <= idling ? pick_odds() : 0;
      end
      send_byte(source_text[i]);
    end
    source_text.delete();
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.char_byte <= 8'h00;
    rst_n           <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identifier closed by a bracket, string holding 0x00 and 0xFF,
    // lone digit, keyword closed by a brace, identifier closed by a quote
    add_text("_a9(");
    source_text.push_back(CH_QUOTE);
    source_text.push_back(8'h00);
    source_text.push_back(8'hFF);
    source_text.push_back(CH_QUOTE);
    add_text("7class{Zz");
    source_text.push_back(CH_QUOTE);
    source_text.push_back(CH_QUOTE);
    add_text("struct\n");
    send_text(1'b1);

    // Random: saturating identifier and string first, then mixed tokens
    add_ident(270);
    add_text(" ");
    add_string(270);
    while (source_text.size() < RANDOM_LEN) add_random_token();
    add_text(" ");
    send_text(1'b1);

    // Last part, no idling: mixed tokens, then halt on a bad byte
    // inside an open identifier and feed bytes that must give nothing
    while (source_text.size() < TAIL_LEN) add_random_token();
    add_text("x9 abc");
    source_text.push_back(8'h01);
    add_text("x;(7");
    source_text.push_back(CH_QUOTE);
    send_text(1'b0);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dtl_pkg.sv
sv/dtl_if.sv
sv/dtl_rqueue.sv
sv/dtl_core.sv
sv/dfa_token_lexer.sv
sim/dtl_token_checker.sv
sim/dfa_token_lexer_tb.sv
